// ===== hdl/cht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants and types for the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int NUM_BUCKETS = 64;
  localparam int CHAIN_DEPTH = 8;
  localparam int BKT_W = $clog2(NUM_BUCKETS);
  localparam int POS_W = $clog2(CHAIN_DEPTH);
  localparam int LEN_W = $clog2(CHAIN_DEPTH + 1);
  localparam int KEY_W = 31;
  localparam int CNT_W = 7;
  localparam int ADDR_W = BKT_W + POS_W;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_DEL_FAIL  = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [BKT_W:0]   divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ===== hdl/chained_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table
// Separate-chaining hash table, key modulo a configured bucket count.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with in_kind/in_key while busy is low. The block computes the
//   bucket with a bit-serial remainder (31 steps), reads the chain length,
//   then walks the chain in the key memory newest first, reading and then
//   comparing each slot. Results appear on out_* for one cycle with out_valid
//   high; out_last marks the final one. The receiver cannot stall.
//   A search reports every matching slot; a delete removes the newest match
//   and shifts the newer slots down to close the gap.
//   An unknown kind produces no result and returns to idle.
//   cfg_valid/cfg_ready writes bucket_count; ready while idle and start low.
//   After reset a pass over all buckets clears chain lengths with busy high;
//   key memory is uninitialized and is never read beyond a chain's length.
// ----------------------------------------------------------------------------
module chained_hash_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_kind,
  input  wire logic [cht_pkg::KEY_W-1:0] in_key,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [cht_pkg::BKT_W-1:0]      out_bucket,
  output logic [cht_pkg::POS_W-1:0]      out_position,
  output logic                           out_last,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [cht_pkg::CNT_W-1:0] cfg_data
);
  import cht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_HASH, S_LEN, S_RD, S_CMP, S_FLUSH, S_SHIFT_RD, S_SHIFT_WR
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       kind_r;
  logic [KEY_W-1:0] key_r;
  logic [BKT_W-1:0] bkt_r;
  logic [BKT_W-1:0] clr_r;
  logic [LEN_W-1:0] len_r, j_r;
  logic             pend_r;
  logic [POS_W-1:0] pend_pos_r;
  logic [LEN_W-1:0] len_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_mem [NUM_BUCKETS*CHAIN_DEPTH];
  logic [LEN_W-1:0] len_rd_r;
  logic [KEY_W-1:0] rd_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic              len_re;
  logic              len_we;
  logic [BKT_W-1:0]  len_waddr;
  logic [LEN_W-1:0]  len_wdata;
  div_req_t          dreq;
  logic              ddone;
  logic [BKT_W-1:0]  drem;
  logic [BKT_W:0]    eff;

  always_comb begin
    if (cnt_r == '0) eff = (BKT_W+1)'(1);
    else if (32'(cnt_r) > NUM_BUCKETS) eff = (BKT_W+1)'(NUM_BUCKETS);
    else eff = (BKT_W+1)'(cnt_r);
  end

  always_comb begin
    dreq.start    = start && !busy;
    dreq.dividend = in_key;
    dreq.divisor  = eff;
  end

  cht_mod u_mod (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .rem(drem));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  // chain length read is issued as the remainder completes
  assign len_re = (state_r == S_HASH) && ddone;

  always_ff @(posedge clk) begin
    if (len_re) len_rd_r <= len_mem[drem];
    if (len_we) len_mem[len_waddr] <= len_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= key_mem[rd_addr];
    if (wr_en) key_mem[wr_addr] <= wr_data;
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = {bkt_r, POS_W'(j_r - 1'b1)};
    wr_en     = 1'b0;
    wr_addr   = {bkt_r, POS_W'(j_r)};
    wr_data   = key_r;
    len_we    = 1'b0;
    len_waddr = bkt_r;
    len_wdata = len_rd_r + 1'b1;
    case (state_r)
      S_CLR: begin
        len_we    = 1'b1;
        len_waddr = clr_r;
        len_wdata = '0;
      end
      S_RD: rd_en = 1'b1;
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = {bkt_r, POS_W'(j_r + 1'b1)};
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_r;
      end
      S_LEN: begin
        wr_en   = (kind_r == KIND_INSERT) && (len_rd_r < LEN_W'(CHAIN_DEPTH));
        wr_addr = {bkt_r, POS_W'(len_rd_r)};
        len_we  = wr_en;
      end
      S_CMP: begin
        len_we    = (kind_r == KIND_DELETE) && (rd_r == key_r);
        len_wdata = len_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      cnt_r     <= CNT_W'(NUM_BUCKETS);
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      out_last  <= 1'b1;
      out_bucket <= bkt_r;
      out_position <= '0;
      if (cfg_valid && cfg_ready) cnt_r <= cfg_data;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BKT_W'(NUM_BUCKETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          kind_r  <= in_kind;
          key_r   <= in_key;
          state_r <= S_HASH;
        end
        S_HASH: if (ddone) begin
          bkt_r   <= drem;
          state_r <= S_LEN;
        end
        S_LEN: begin
          len_r  <= len_rd_r;
          j_r    <= len_rd_r;
          pend_r <= 1'b0;
          case (kind_r)
            KIND_INSERT: begin
              out_valid <= 1'b1;
              if (len_rd_r >= LEN_W'(CHAIN_DEPTH)) out_status <= ST_FULL;
              else out_status <= ST_INSERTED;
              state_r <= S_IDLE;
            end
            KIND_SEARCH, KIND_DELETE: begin
              if (len_rd_r == '0) begin
                out_valid  <= 1'b1;
                out_status <= (kind_r == KIND_SEARCH) ? ST_NOT_FOUND : ST_DEL_FAIL;
                state_r    <= S_IDLE;
              end else state_r <= S_RD;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (kind_r == KIND_SEARCH) begin
            // a hit is held back one step so the final one can carry last
            if (rd_r == key_r) begin
              pend_r     <= 1'b1;
              pend_pos_r <= POS_W'(len_r - j_r);
              if (pend_r) begin
                out_valid    <= 1'b1;
                out_status   <= ST_FOUND;
                out_position <= pend_pos_r;
                out_last     <= 1'b0;
              end
            end
            if (j_r == LEN_W'(1)) begin
              if ((rd_r == key_r) || pend_r) state_r <= S_FLUSH;
              else begin
                out_valid  <= 1'b1;
                out_status <= ST_NOT_FOUND;
                state_r    <= S_IDLE;
              end
            end else begin
              j_r     <= j_r - 1'b1;
              state_r <= S_RD;
            end
          end else if (rd_r == key_r) begin
            out_valid    <= 1'b1;
            out_status   <= ST_DELETED;
            out_position <= POS_W'(len_r - j_r);
            j_r          <= j_r - 1'b1;
            state_r      <= (j_r == len_r) ? S_IDLE : S_SHIFT_RD;
          end else if (j_r == LEN_W'(1)) begin
            out_valid  <= 1'b1;
            out_status <= ST_DEL_FAIL;
            state_r    <= S_IDLE;
          end else begin
            j_r     <= j_r - 1'b1;
            state_r <= S_RD;
          end
        end
        S_FLUSH: begin
          out_valid    <= 1'b1;
          out_status   <= ST_FOUND;
          out_position <= pend_pos_r;
          state_r      <= S_IDLE;
        end
        // j_r is the slot being filled from slot j_r+1
        S_SHIFT_RD: state_r <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (j_r + LEN_W'(2) >= len_r) state_r <= S_IDLE;
          else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_SHIFT_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The last result of an item never shows in S_RD or S_SHIFT_WR.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !(state_r == S_RD || state_r == S_SHIFT_WR))
    else $error("last result while work remains");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HASH) |-> !cfg_ready)
    else $error("config ready while busy");
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_bucket} < eff))
    else $error("bucket beyond count");
endmodule
`default_nettype wire

// ===== hdl/cht_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_mod
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cht_mod (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cht_pkg::div_req_t       req,
  output logic                         done,
  output logic [cht_pkg::BKT_W-1:0]    rem
);
  import cht_pkg::*;
  localparam int CW = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] dvd_r;
  logic [BKT_W:0]   dsr_r;
  logic [BKT_W+1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [BKT_W+1:0] trial;

  always_comb trial = {rem_r[BKT_W:0], dvd_r[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= CW'(KEY_W);
      end else if (busy_r) begin
        dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr_r}) rem_r <= trial - {1'b0, dsr_r};
        else rem_r <= trial;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rem = rem_r[BKT_W-1:0];
endmodule
`default_nettype wire

// ===== tb/sv/chained_hash_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_tb
// Drives insert/search/delete items at the table with random gaps, keeps a
// behavioral copy of every chain, and checks each result strobe field by
// field against the expected-result queue. Bucket count is changed between
// phases, extremes included.
// ----------------------------------------------------------------------------
module chained_hash_table_tb;
  import cht_pkg::*;

  typedef struct packed {
    logic [2:0]       status;
    logic [BKT_W-1:0] bucket;
    logic [POS_W-1:0] position;
    logic             last;
  } cht_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_kind = '0;
  logic [KEY_W-1:0]     in_key = '0;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [BKT_W-1:0]     out_bucket;
  logic [POS_W-1:0]     out_position;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data = '0;

  chained_hash_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_key(in_key),
    .out_valid(out_valid), .out_status(out_status), .out_bucket(out_bucket),
    .out_position(out_position), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow table: slots oldest first
  logic [KEY_W-1:0] shadow_keys [NUM_BUCKETS][CHAIN_DEPTH];
  int unsigned      shadow_len [NUM_BUCKETS];
  logic [CNT_W-1:0] bucket_count_q;
  cht_result_t      pending_results [$];
  int               error_count = 0;
  int               sender_idle_pct = 0;
  longint           cycle_count = 0;
  logic [KEY_W-1:0] recent_keys [$];

  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR t=%0t: %s", $time, what);
  endtask

  function automatic int unsigned live_buckets();
    int unsigned n;
    n = bucket_count_q;
    if (n == 0) n = 1;
    if (n > NUM_BUCKETS) n = NUM_BUCKETS;
    return n;
  endfunction

  task automatic predict_table_op(input logic [1:0] kind, input logic [KEY_W-1:0] key);
    int unsigned b, len, hits;
    cht_result_t r;
    b = key % live_buckets();
    len = shadow_len[b];
    hits = 0;
    r.bucket = b[BKT_W-1:0];
    r.position = '0;
    r.last = 1'b1;
    case (kind)
      KIND_INSERT: begin
        if (len >= CHAIN_DEPTH) r.status = ST_FULL;
        else begin
          shadow_keys[b][len] = key;
          shadow_len[b] = len + 1;
          r.status = ST_INSERTED;
        end
        pending_results.push_back(r);
      end
      KIND_SEARCH: begin
        for (int j = len; j > 0 && hits < CHAIN_DEPTH; j--) begin
          if (shadow_keys[b][j-1] == key) begin
            r.status = ST_FOUND;
            r.position = POS_W'(len - j);
            r.last = 1'b0;
            pending_results.push_back(r);
            hits++;
          end
        end
        if (hits == 0) begin
          r.status = ST_NOT_FOUND;
          pending_results.push_back(r);
        end else pending_results[$].last = 1'b1;
      end
      KIND_DELETE: begin
        r.status = ST_DEL_FAIL;
        for (int j = len; j > 0; j--) begin
          if (shadow_keys[b][j-1] == key) begin
            for (int s = j - 1; s + 1 < len; s++) shadow_keys[b][s] = shadow_keys[b][s+1];
            shadow_len[b] = len - 1;
            r.status = ST_DELETED;
            r.position = POS_W'(len - j);
            break;
          end
        end
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0)
        report_mismatch("result with nothing expected");
      else begin
        cht_result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_bucket !== e.bucket)
          report_mismatch($sformatf("bucket %0d, want %0d", out_bucket, e.bucket));
        if (out_position !== e.position)
          report_mismatch($sformatf("position %0d, want %0d", out_position, e.position));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [KEY_W-1:0] key);
    while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) @(posedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    do @(posedge clk); while (busy);
    predict_table_op(kind, key);
    if (recent_keys.size() > 12) void'(recent_keys.pop_front());
    recent_keys.push_back(key);
    start <= 1'b0;
    in_kind <= 2'($urandom);
    in_key <= KEY_W'($urandom);
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    bucket_count_q = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(KIND_SEARCH, '0);
    send_item(KIND_DELETE, '1);
    send_item(KIND_INSERT, '1);
    send_item(KIND_INSERT, '0);
    for (int i = 0; i < 9; i++) send_item(KIND_INSERT, 31'd128);  // fills bucket 0, last 2 full
    send_item(KIND_SEARCH, 31'd128);
    send_item(KIND_DELETE, 31'd128);
    send_item(KIND_DELETE, 31'd0);
    send_item(KIND_SEARCH, '1);
    send_item(KIND_RSVD, 31'h2AAAAAAA);
    send_item(KIND_DELETE, '1);
    send_item(KIND_SEARCH, 31'h55555555);
  endtask

  task automatic test_random(input int items, input int key_span);
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < items; i++) begin
      kind = $urandom_range(99, 0) < 45 ? KIND_INSERT : 2'($urandom_range(2, 1));
      if ($urandom_range(19, 0) == 0) kind = KIND_RSVD;
      if (kind != KIND_INSERT && recent_keys.size() != 0 && $urandom_range(3, 0) != 0)
        key = recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
      else if ($urandom_range(9, 0) == 0) key = KEY_W'($urandom);
      else key = KEY_W'($urandom_range(key_span, 0));
      send_item(kind, key);
    end
  endtask

  task automatic test_bucket_counts();
    write_bucket_count(7'd1);
    test_random(40, 20);
    write_bucket_count(7'd0);
    test_random(15, 40);
    write_bucket_count(7'd127);
    test_random(25, 300);
    write_bucket_count(7'd5);
    test_random(40, 60);
  endtask

  initial begin
    for (int b = 0; b < NUM_BUCKETS; b++) shadow_len[b] = 0;
    bucket_count_q = 7'd64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(30, 200);
    sender_idle_pct = 81;
    test_bucket_counts();
    drain_results();  // sender holds off until every result is in
    sender_idle_pct = 33;
    write_bucket_count(7'd64);
    test_random(40, 500);
    drain_results();
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
